// ----- sv/bru_pkg.sv -----
// Package for the branch unit: branch form codes, BO bit positions and stage records.
// Used by every stage module and by the top level; depends on nothing.
`timescale 1ns / 1ps

package bru_pkg;

    typedef enum logic [1:0] {
        FORM_B     = 2'd0,
        FORM_BC    = 2'd1,
        FORM_BCLR  = 2'd2,
        FORM_BCCTR = 2'd3
    } form_t;

    localparam int BO_NO_CR   = 4;
    localparam int BO_CR_SET  = 3;
    localparam int BO_NO_CTR  = 2;
    localparam int BO_CTR_EQZ = 1;

    localparam logic [63:0] ADDR_LOW32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] WORD_ALIGN = ~64'h3;
    localparam logic [63:0] INSN_BYTES = 64'h4;

    typedef struct packed {
        form_t       form;
        logic [63:0] cia;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic [23:0] disp;
        logic        aa;
        logic        lk;
        logic [31:0] cr;
        logic [63:0] ctr;
        logic [63:0] lr;
        logic        sf;
    } req_t;

    typedef struct packed {
        form_t       form;
        logic [63:0] cia;
        logic [63:0] seq;
        logic [63:0] off;
        logic        aa;
        logic        lk;
        logic        cwrite;
        logic [63:0] cnew;
        logic        ctr_eqz;
        logic        cr_ok;
        logic [63:0] lr_al;
        logic [63:0] ctr_al;
        logic        sf;
    } dec_t;

    typedef struct packed {
        logic        taken;
        logic [63:0] target;
        logic [63:0] seq;
        logic        cwrite;
        logic [63:0] cnew;
        logic        lk;
        logic        sf;
    } res_t;

    typedef struct packed {
        logic        taken;
        logic [63:0] next_addr;
        logic        count_write;
        logic [63:0] count_new;
        logic        link_write;
        logic [63:0] link_new;
    } out_t;

endpackage

// ----- sv/bru_decode.sv -----
// First stage: sequential address, CTR decrement, CR bit test, displacement extension and LR/CTR alignment.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  bru_pkg::req_t req,
    output logic          dec_valid,
    output bru_pkg::dec_t dec
);

    logic          valid_reg;
    bru_pkg::dec_t data_reg;
    bru_pkg::dec_t data_next;

    always_comb
    begin
        data_next.form = req.form;
        data_next.cia  = req.cia;
        data_next.seq  = req.cia + bru_pkg::INSN_BYTES;
        if (req.form == bru_pkg::FORM_B)
        begin
            data_next.off = {{38{req.disp[23]}}, req.disp, 2'b00};
        end
        else
        begin
            data_next.off = {{48{req.disp[13]}}, req.disp[13:0], 2'b00};
        end
        data_next.aa      = req.aa;
        data_next.lk      = req.lk;
        data_next.cwrite  = (req.form == bru_pkg::FORM_BC || req.form == bru_pkg::FORM_BCLR)
                            && !req.bo[bru_pkg::BO_NO_CTR];
        data_next.cnew    = data_next.cwrite ? (req.ctr - 64'd1) : 64'd0;
        data_next.ctr_eqz = req.bo[bru_pkg::BO_CTR_EQZ];
        data_next.cr_ok   = req.bo[bru_pkg::BO_NO_CR]
                            || (req.cr[5'd31 - req.bi] == req.bo[bru_pkg::BO_CR_SET]);
        data_next.lr_al   = req.lr & bru_pkg::WORD_ALIGN;
        data_next.ctr_al  = req.ctr & bru_pkg::WORD_ALIGN;
        data_next.sf      = req.sf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = data_reg;

endmodule

// ----- sv/bru_resolve.sv -----
// Second stage: CTR zero test, branch decision and target address.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_resolve (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          dec_valid,
    input  bru_pkg::dec_t dec,
    output logic          res_valid,
    output bru_pkg::res_t res
);

    logic          valid_reg;
    bru_pkg::res_t data_reg;
    bru_pkg::res_t data_next;
    logic          ctr_zero;
    logic          ctr_fail;

    always_comb
    begin
        ctr_zero = dec.sf ? (dec.cnew == 64'd0) : (dec.cnew[31:0] == 32'd0);
        ctr_fail = dec.cwrite && (dec.ctr_eqz ? !ctr_zero : ctr_zero);
        data_next.taken = (dec.form == bru_pkg::FORM_B) || (!ctr_fail && dec.cr_ok);
        case (dec.form)
            bru_pkg::FORM_B, bru_pkg::FORM_BC:
            begin
                data_next.target = dec.aa ? dec.off : (dec.cia + dec.off);
            end
            bru_pkg::FORM_BCLR:
            begin
                data_next.target = dec.lr_al;
            end
            default:
            begin
                data_next.target = dec.ctr_al;
            end
        endcase
        data_next.seq    = dec.seq;
        data_next.cwrite = dec.cwrite;
        data_next.cnew   = dec.cnew;
        data_next.lk     = dec.lk;
        data_next.sf     = dec.sf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

// ----- sv/bru_writeback.sv -----
// Third stage: next address selection, 32-bit mode truncation and the result register.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_writeback (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  bru_pkg::res_t res,
    output logic          out_valid,
    output bru_pkg::out_t out
);

    logic          valid_reg;
    bru_pkg::out_t data_reg;
    bru_pkg::out_t data_next;
    logic [63:0]   addr_mask;

    always_comb
    begin
        addr_mask              = res.sf ? ~64'd0 : bru_pkg::ADDR_LOW32;
        data_next.taken        = res.taken;
        data_next.next_addr    = (res.taken ? res.target : res.seq) & addr_mask;
        data_next.count_write  = res.cwrite;
        data_next.count_new    = res.cnew;
        data_next.link_write   = res.lk;
        data_next.link_new     = (res.lk ? res.seq : 64'd0) & addr_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out       = data_reg;

endmodule

// ----- sv/powerpc_branch_unit.sv -----
// Top level of the branch unit: ties the decode, resolve and writeback stages together.
// Depends on bru_pkg, bru_decode, bru_resolve and bru_writeback.
`timescale 1ns / 1ps

// A branch is taken in on every cycle that start is high; busy is always low, since the
// result side cannot stall. Each result passes through the three register stages in turn:
// decode with the CIA+4 and CTR-1 adders, resolve with the target adder and CTR zero test,
// and the output register after address selection. It is then on the outputs with done
// high for one cycle; results leave in the order the branches came in.
module powerpc_branch_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] cur_addr,
    input  logic [4:0]  bo_field,
    input  logic [4:0]  bi_field,
    input  logic [23:0] disp_field,
    input  logic        abs_flag,
    input  logic        link_flag,
    input  logic [31:0] cond_reg,
    input  logic [63:0] count_reg,
    input  logic [63:0] link_reg,
    input  logic        mode64,
    output logic        done,
    output logic        taken,
    output logic [63:0] next_addr,
    output logic        count_write,
    output logic [63:0] count_new,
    output logic        link_write,
    output logic [63:0] link_new
);

    bru_pkg::req_t req;
    bru_pkg::dec_t dec;
    bru_pkg::res_t res;
    bru_pkg::out_t out;
    logic          dec_valid;
    logic          res_valid;
    logic          out_valid;

    assign busy = 1'b0;

    always_comb
    begin
        req.form = bru_pkg::form_t'(req_type);
        req.cia  = cur_addr;
        req.bo   = bo_field;
        req.bi   = bi_field;
        req.disp = disp_field;
        req.aa   = abs_flag;
        req.lk   = link_flag;
        req.cr   = cond_reg;
        req.ctr  = count_reg;
        req.lr   = link_reg;
        req.sf   = mode64;
    end

    bru_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (req),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    bru_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .res_valid (res_valid),
        .res       (res)
    );

    bru_writeback u_writeback (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out       (out)
    );

    assign done        = out_valid;
    assign taken       = out.taken;
    assign next_addr   = out.next_addr;
    assign count_write = out.count_write;
    assign count_new   = out.count_new;
    assign link_write  = out.link_write;
    assign link_new    = out.link_new;

endmodule
